[hdl/mts_pkg.sv]
// ----------------------------------------------------------------------------
// mts_pkg: shared types and codes for the midtone transfer stretch core
// Holds the configuration register indexes and the special-case flag struct.
// ----------------------------------------------------------------------------
package mts_pkg;

    // Configuration register index
    typedef logic [1:0] t_cfg_idx;

    localparam t_cfg_idx CFG_SHADOW    = 2'd0;
    localparam t_cfg_idx CFG_HIGHLIGHT = 2'd1;
    localparam t_cfg_idx CFG_MIDTONE   = 2'd2;

    localparam int CFG_DATA_BITS = 16;

    // Special-case flags that travel with each pixel down the chain
    typedef struct packed {
        logic zero;   // pixel at or below shadow
        logic full;   // empty range or pixel at or above highlight
        logic mid;    // rescaled pixel equals the midtone balance
    } t_flags;

endpackage

[hdl/mts_prep.sv]
// ----------------------------------------------------------------------------
// mts_prep: operand preparation for the stretch divider
// Two stages: clip offsets and products, then numerator/denominator sums.
// ----------------------------------------------------------------------------
module mts_prep #(
    parameter int B = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  logic [B-1:0]         i_pix,
    input  logic [B-1:0]         i_shadow,
    input  logic [B-1:0]         i_highlight,
    input  logic [B-1:0]         i_midtone,
    output logic                 o_valid,
    output mts_pkg::t_flags      o_flags,
    output logic [3*B-1:0]       o_num,
    output logic [2*B:0]         o_den
);

    localparam logic [B-1:0] FULL = {B{1'b1}};

    // Stage 1 registers
    logic            r_v1;
    logic            r_zero1, r_full1;
    logic [B-1:0]    r_a1;
    logic [2*B-1:0]  r_p1, r_p2, r_p3;

    // Stage 2 registers
    logic            r_v2;
    mts_pkg::t_flags r_flags2;
    logic [3*B-1:0]  r_num2;
    logic [2*B:0]    r_den2;

    logic [B-1:0]    n_fm;
    logic [B-1:0]    n_a, n_hp, n_hs;
    logic [2*B-1:0]  n_aF;

    assign n_fm = FULL - i_midtone;
    assign n_a  = i_pix - i_shadow;
    assign n_hp = i_highlight - i_pix;
    assign n_hs = i_highlight - i_shadow;
    assign n_aF = {r_a1, {B{1'b0}}} - {{B{1'b0}}, r_a1};

    // Advance valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
    end

    // Compute offsets, flags and the three products
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_zero1 <= (i_pix <= i_shadow);
            r_full1 <= (i_highlight <= i_shadow) || (i_pix >= i_highlight);
            r_a1    <= n_a;
            r_p1    <= {{B{1'b0}}, n_fm} * {{B{1'b0}}, n_a};
            r_p2    <= {{B{1'b0}}, i_midtone} * {{B{1'b0}}, n_hp};
            r_p3    <= {{B{1'b0}}, i_midtone} * {{B{1'b0}}, n_hs};
        end
    end

    // Form numerator F*P1, denominator P1+P2 and the midtone compare
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_flags2.zero <= r_zero1;
            r_flags2.full <= r_full1;
            r_flags2.mid  <= (n_aF == r_p3);
            r_num2 <= {r_p1, {B{1'b0}}} - {{B{1'b0}}, r_p1};
            r_den2 <= {1'b0, r_p1} + {1'b0, r_p2};
        end
    end

    assign o_valid = r_v2;
    assign o_flags = r_flags2;
    assign o_num   = r_num2;
    assign o_den   = r_den2;

endmodule

[hdl/mts_div_cell.sv]
// ----------------------------------------------------------------------------
// mts_div_cell: one restoring-division cell
// Resolves one quotient bit and hands remainder and quotient to the next cell.
// ----------------------------------------------------------------------------
module mts_div_cell #(
    parameter int B = 16,
    parameter int K = 0
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  mts_pkg::t_flags      i_flags,
    input  logic [3*B-1:0]       i_rem,
    input  logic [2*B:0]         i_den,
    input  logic [B-1:0]         i_q,
    output logic                 o_valid,
    output mts_pkg::t_flags      o_flags,
    output logic [3*B-1:0]       o_rem,
    output logic [2*B:0]         o_den,
    output logic [B-1:0]         o_q
);

    logic            r_valid;
    mts_pkg::t_flags r_flags;
    logic [3*B-1:0]  r_rem;
    logic [2*B:0]    r_den;
    logic [B-1:0]    r_q;

    logic [3*B-1:0]  n_dsh;
    logic            n_bit;

    assign n_dsh = {{(B-1){1'b0}}, i_den} << K;
    assign n_bit = (i_rem >= n_dsh);

    // Advance valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    // Subtract the shifted divisor when it fits and shift in the bit
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_flags <= i_flags;
            r_den   <= i_den;
            r_rem   <= n_bit ? (i_rem - n_dsh) : i_rem;
            r_q     <= {i_q[B-2:0], n_bit};
        end
    end

    assign o_valid = r_valid;
    assign o_flags = r_flags;
    assign o_rem   = r_rem;
    assign o_den   = r_den;
    assign o_q     = r_q;

endmodule

[hdl/midtone_transfer_stretch_core.sv]
// ----------------------------------------------------------------------------
// midtone_transfer_stretch_core: histogram stretch with midtones transfer
// Clips each pixel between shadow and highlight, then applies the MTF.
// ----------------------------------------------------------------------------
// Usage:
//   Write shadow, highlight and midtone balance on the config port (index
//   0, 1, 2) while no transaction is in flight. Pixels enter on the
//   i_valid/o_ready channel and results leave on o_valid/i_ready.
//   Throughput is one pixel per clock while the chain is not held.
//   Pixels pass two operand stages and then a chain of PIXEL_BITS
//   divider cells, each resolving one quotient bit. The last cell is
//   the output register. While a result waits unaccepted at the output,
//   the whole chain holds and o_ready drops.
//   Reset empties the chain and loads shadow 0, highlight full scale and
//   midtone balance at half scale (identity transfer).
// ----------------------------------------------------------------------------
module midtone_transfer_stretch_core #(
    parameter int PIXEL_BITS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  mts_pkg::t_cfg_idx    i_cfg_idx,
    input  logic [15:0]          i_cfg_data,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [15:0]          i_pixel_in,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [15:0]          o_pixel_out
);

    localparam int B = PIXEL_BITS;
    localparam logic [B-1:0] FULL = {B{1'b1}};
    localparam logic [B-1:0] HALF = {1'b1, {(B-1){1'b0}}};
    localparam logic [B-1:0] MIDV = {1'b0, {(B-1){1'b1}}};

    logic [B-1:0] r_shadow, r_highlight, r_midtone;
    logic         n_en;

    // Hold configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shadow    <= '0;
            r_highlight <= FULL;
            r_midtone   <= HALF;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                mts_pkg::CFG_SHADOW:    r_shadow    <= i_cfg_data[B-1:0];
                mts_pkg::CFG_HIGHLIGHT: r_highlight <= i_cfg_data[B-1:0];
                mts_pkg::CFG_MIDTONE:   r_midtone   <= i_cfg_data[B-1:0];
                default: ;
            endcase
        end
    end

    // Chain wiring: entry 0 is the prep output, entry B the last cell
    logic             w_v   [B+1];
    mts_pkg::t_flags  w_f   [B+1];
    logic [3*B-1:0]   w_rem [B+1];
    logic [2*B:0]     w_den [B+1];
    logic [B-1:0]     w_q   [B+1];

    // Advance the chain unless a result waits unaccepted at the output
    assign n_en    = !w_v[B] || i_ready;
    assign o_ready = n_en;

    mts_prep #(.B(B)) u_prep (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (n_en),
        .i_valid     (i_valid),
        .i_pix       (i_pixel_in[B-1:0]),
        .i_shadow    (r_shadow),
        .i_highlight (r_highlight),
        .i_midtone   (r_midtone),
        .o_valid     (w_v[0]),
        .o_flags     (w_f[0]),
        .o_num       (w_rem[0]),
        .o_den       (w_den[0])
    );

    assign w_q[0] = '0;

    genvar gi;
    generate
        for (gi = 0; gi < B; gi++) begin : g_cell
            mts_div_cell #(.B(B), .K(B-1-gi)) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_en    (n_en),
                .i_valid (w_v[gi]),
                .i_flags (w_f[gi]),
                .i_rem   (w_rem[gi]),
                .i_den   (w_den[gi]),
                .i_q     (w_q[gi]),
                .o_valid (w_v[gi+1]),
                .o_flags (w_f[gi+1]),
                .o_rem   (w_rem[gi+1]),
                .o_den   (w_den[gi+1]),
                .o_q     (w_q[gi+1])
            );
        end
    endgenerate

    // Select the special-case value or the quotient
    logic [B-1:0] n_pix;
    always_comb begin
        if (w_f[B].zero)
            n_pix = '0;
        else if (w_f[B].full)
            n_pix = FULL;
        else if (w_f[B].mid)
            n_pix = MIDV;
        else
            n_pix = w_q[B];
    end

    assign o_valid     = w_v[B];
    assign o_pixel_out = 16'(n_pix);

endmodule
